@@ rtl/kmm_pkg.sv @@
// Shared types and constants for the k-way merge selector.
// No dependencies; every other file of the block except kmm_ram imports this package.
package kmm_pkg;

  localparam int STREAM_W = 4;
  localparam int VALUE_W  = 64;
  // Number of stream indexes a load word can address.
  localparam int STREAM_SPACE = 1 << STREAM_W;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef struct packed {
    logic                       op;
    logic [STREAM_W-1:0]        stream;
    logic signed [VALUE_W-1:0]  value;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  min_value;
    logic [STREAM_W-1:0]        min_stream;
    logic                       last;
    logic                       empty_res;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // write the input word's value as a stream head
    logic clear;   // start of a pop: forget the previous best head
    logic rd_en;   // a head read is issued this cycle
    logic finish;  // write the result word and retire the best head
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;  // the output register can take a word this cycle
  } stat_t;

endpackage

@@ rtl/kway_min_merge_select.sv @@
// Merge selector for a k-way merge sort.
// Channels: in_valid/in_ready/in_data carries load and pop words; out_valid/
// out_ready/out_data carries one result word for each pop.
// A load word writes in_data.value as the head of stream in_data.stream and
// marks it valid; a load to a stream at or above the stream count is dropped.
// It gives no result, and the block stays ready for the next word.
// A pop word scans every addressable head, one RAM read per cycle, and keeps
// the smallest signed value (lowest stream on ties). The scan length is the
// stream count N = min(WAYS, 16). After the scan a wait state compares the
// last read; the result is then written once the output register is free,
// and the block takes the next word in the cycle after. It takes no new word
// during a pop; the single read port of the head RAM makes the scan serial.
// If no head is valid the result has empty_res set and all else zero.
// Reset marks every head empty; no clearing pass runs.
// A finished result sits in the output register until taken. Loads are
// still accepted meanwhile; a following pop runs its scan and then waits
// until the output register is free.
// Depends on kmm_pkg, kmm_ctrl, kmm_dp and kmm_ram.
module kway_min_merge_select import kmm_pkg::*; #(
  parameter int WAYS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int NSTREAM = (WAYS < STREAM_SPACE) ? WAYS : STREAM_SPACE;
  localparam int IW      = $clog2(NSTREAM);

  cmd_t          cmd;
  stat_t         status;
  logic [IW-1:0] rd_idx;

  kmm_ctrl #(
    .NSTREAM(NSTREAM)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  kmm_dp #(
    .NSTREAM(NSTREAM)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .rd_idx    (rd_idx),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  a_pop_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.op == OP_POP) |=> !in_ready)
    else $error("pop accepted but block still ready");

  a_finish_has_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("result written over a word still waiting");

  a_finish_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid)
    else $error("finished pop did not raise out_valid");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.empty_res |->
      (out_data.min_value == '0) && (out_data.min_stream == '0) && !out_data.last)
    else $error("empty result carries nonzero fields");
`endif

endmodule

@@ rtl/kmm_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module kmm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/kmm_ctrl.sv @@
// Controller of the merge selector: accepts words and sequences the head scan.
// Depends on kmm_pkg for the command and status types.
module kmm_ctrl import kmm_pkg::*; #(
  parameter int NSTREAM = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_op,
  output logic                       in_ready,
  input  stat_t                      status,
  output cmd_t                       cmd,
  output logic [$clog2(NSTREAM)-1:0] rd_idx
);

  localparam int IW = $clog2(NSTREAM);
  localparam logic [IW-1:0] LAST_IDX = IW'(NSTREAM - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [IW-1:0] cnt_r, cnt_nxt;
  logic          accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign rd_idx   = cnt_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd.load   = 1'b0;
    cmd.clear  = 1'b0;
    cmd.rd_en  = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_POP) begin
            cmd.clear = 1'b1;
            cnt_nxt   = '0;
            state_nxt = ST_SCAN;
          end else begin
            cmd.load = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        cmd.rd_en = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_WAIT;
        end
      end
      // The last head read is compared in this cycle.
      ST_WAIT: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

@@ rtl/kmm_dp.sv @@
// Datapath of the merge selector: head store, valid marks, running minimum
// and output register. Depends on kmm_pkg and kmm_ram.
module kmm_dp import kmm_pkg::*; #(
  parameter int NSTREAM = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  in_word_t                   in_data,
  input  cmd_t                       cmd,
  input  logic [$clog2(NSTREAM)-1:0] rd_idx,
  output stat_t                      status,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_word_t                  out_data
);

  localparam int IW = $clog2(NSTREAM);

  logic [NSTREAM-1:0]        valid_r, valid_nxt;
  logic                      cmp_v_r;
  logic [IW-1:0]             cmp_idx_r;
  logic signed [VALUE_W-1:0] rd_data;
  logic                      found_r;
  logic [IW-1:0]             best_idx_r;
  logic signed [VALUE_W-1:0] best_val_r;
  logic                      take;
  logic                      in_range;
  logic                      wr_en;
  logic [NSTREAM-1:0]        rest;
  logic                      out_valid_r;
  out_word_t                 out_data_r, out_word;

  assign in_range = ({1'b0, in_data.stream} < (STREAM_W + 1)'(NSTREAM));
  assign wr_en    = cmd.load && in_range;

  kmm_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(NSTREAM)
  ) u_heads (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.stream[IW-1:0]),
    .wr_data (in_data.value),
    .rd_addr (rd_idx),
    .rd_data (rd_data)
  );

  // Streams are scanned in ascending order, so a strict compare keeps the
  // lowest index on ties.
  assign take = cmp_v_r && valid_r[cmp_idx_r] && (!found_r || (rd_data < best_val_r));

  assign rest = valid_r & ~(NSTREAM'(1) << best_idx_r);

  always_comb begin
    out_word = '0;
    if (found_r) begin
      out_word.min_value  = best_val_r;
      out_word.min_stream = STREAM_W'(best_idx_r);
      out_word.last       = (rest == '0);
    end else begin
      out_word.empty_res = 1'b1;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    if (wr_en) begin
      valid_nxt[in_data.stream[IW-1:0]] = 1'b1;
    end
    if (cmd.finish && found_r) begin
      valid_nxt = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      cmp_v_r     <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      cmp_v_r <= cmd.rd_en;
      if (cmd.clear) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx_r <= rd_idx;
    if (take) begin
      best_idx_r <= cmp_idx_r;
      best_val_r <= rd_data;
    end
    if (cmd.finish) begin
      out_data_r <= out_word;
    end
  end

  assign status.out_free = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign out_data        = out_data_r;

endmodule
